// ===== design/pdd_pkg.sv =====
// Shared types, codes and constants of the parking distance display core.
package pdd_pkg;

  // Defaults for the top-level parameters.
  localparam int DIST_BITS_DEF     = 16;
  localparam int PCT_FRAC_BITS_DEF = 8;

  // Fixed field widths.
  localparam int MM_W      = 16;
  localparam int PCT_INT_W = 10;
  localparam int SEG_W     = 7;
  localparam int BAR_LEDS  = 8;
  localparam int KIND_W    = 2;
  localparam int ZONE_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_MEAS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEACT  = 2'd2;

  // Zones.
  localparam logic [ZONE_W-1:0] ZONE_OK      = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_CONTACT = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_NONE    = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MAX = 2'd3;

  localparam logic [MM_W-1:0] MIN_MM_RST = 16'd200;
  localparam logic [MM_W-1:0] MAX_MM_RST = 16'd1000;

  localparam logic [SEG_W-1:0] SEG_DASH  = 7'h40;
  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

  // Status of the shared divider.
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  // Segment codes of one side, with the stage that marks them new.
  typedef struct packed {
    logic             done;
    logic [SEG_W-1:0] hund;
    logic [SEG_W-1:0] tens;
    logic [SEG_W-1:0] ones;
  } dig_res_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
    logic [SEG_W-1:0] s;
    case (digit)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ===== design/pdd_div.sv =====
// Shared restoring divider, one quotient bit per cycle, with overflow detect.
module pdd_div #(
  parameter int NW = 31,
  parameter int PW = 18,
  parameter int SW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NW-1:0]       num,
  input  logic [SW-1:0]       den,
  output pdd_pkg::div_stat_t  stat,
  output logic [PW-1:0]       quo
);

  localparam int CW = $clog2(PW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] sh_r, sh_nxt;
  logic [SW-1:0] den_r, den_nxt;
  logic          done_r, done_nxt;
  logic          ovf_r, ovf_nxt;
  logic [SW:0]   trial;
  logic          qbit;

  assign trial = {rem_r, sh_r[PW-1]};
  assign qbit  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    if (start) begin
      den_nxt = den;
      rem_nxt = SW'(num[NW-1:PW]);
      sh_nxt  = num[PW-1:0];
      cnt_nxt = CW'(PW);
      // A high part at or above the divisor means the quotient does not fit.
      ovf_nxt = SW'(num[NW-1:PW]) >= den;
      if (SW'(num[NW-1:PW]) >= den) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = qbit ? SW'(trial - {1'b0, den_r}) : trial[SW-1:0];
      sh_nxt  = {sh_r[PW-2:0], qbit};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign quo       = sh_r;

endmodule

// ===== design/pdd_digits.sv =====
// Two-stage conversion of one percent into three seven-segment codes.
module pdd_digits #(
  parameter int PCT_FRAC_BITS = pdd_pkg::PCT_FRAC_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic [pdd_pkg::PCT_INT_W+PCT_FRAC_BITS-1:0]  q,
  output pdd_pkg::dig_res_t                            res
);

  localparam int PW = pdd_pkg::PCT_INT_W + PCT_FRAC_BITS;
  localparam logic [PW-1:0] PCT_20 = PW'(20) << PCT_FRAC_BITS;

  logic [pdd_pkg::PCT_INT_W-1:0] p;
  logic [15:0]                   h_prod;
  logic [3:0]                    h_c;
  logic [pdd_pkg::PCT_INT_W-1:0] rem_c;

  logic       v1_r, v2_r;
  logic       dash_r;
  logic [3:0] h_r;
  logic [6:0] rem_r;

  logic [14:0] t_prod;
  logic [3:0]  t_c;
  logic [6:0]  o_c;

  logic [pdd_pkg::SEG_W-1:0] hund_r, tens_r, ones_r;
  logic [pdd_pkg::SEG_W-1:0] hund_nxt, tens_nxt, ones_nxt;

  // The percent never exceeds 999, so p*41/4096 gives the hundreds digit.
  assign p      = q[PW-1:PCT_FRAC_BITS];
  assign h_prod = 16'(p) * 16'd41;
  assign h_c    = h_prod[15:12];
  assign rem_c  = p - pdd_pkg::PCT_INT_W'(h_c) * pdd_pkg::PCT_INT_W'(100);

  // For a remainder below 100, r*205/2048 gives the tens digit.
  assign t_prod = 15'(rem_r) * 15'd205;
  assign t_c    = t_prod[14:11];
  assign o_c    = rem_r - 7'(t_c) * 7'd10;

  always_comb begin
    if (dash_r) begin
      hund_nxt = pdd_pkg::SEG_DASH;
      tens_nxt = pdd_pkg::SEG_DASH;
      ones_nxt = pdd_pkg::SEG_DASH;
    end else begin
      hund_nxt = (h_r != 4'd0) ? pdd_pkg::seg_of(h_r) : pdd_pkg::SEG_BLANK;
      tens_nxt = pdd_pkg::seg_of(t_c);
      ones_nxt = pdd_pkg::seg_of(o_c[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
    if (start) begin
      dash_r <= q <= PCT_20;
      h_r    <= h_c;
      rem_r  <= rem_c[6:0];
    end
    if (v1_r) begin
      hund_r <= hund_nxt;
      tens_r <= tens_nxt;
      ones_r <= ones_nxt;
    end
  end

  assign res.done = v2_r;
  assign res.hund = hund_r;
  assign res.tens = tens_r;
  assign res.ones = ones_r;

endmodule

// ===== design/parking_distance_display_core.sv =====
// Parking distance display core: sequencer, state and result register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_tvalid/in_tready  | tuser: kind; tdata: left_mm, right_mm
//   out      | out_tvalid/out_tready| tdata: status, bar, percents, zone, segs
//   cfg      | cfg_we               | cfg_index, cfg_wdata
//
// A measurement item takes, per percent in turn, a setup step, the shared
// restoring divider and the digit decode, then an update and an output step;
// a zero or negative span, a distance at or below the minimum or an overflowing
// quotient shortens its side. Other kinds take only the update and output steps.
// in_tready is high only while the sequencer is idle, and one finished result
// may wait in the output register. Reset is synchronous but skips datapath regs.
module parking_distance_display_core #(
  parameter int DIST_BITS     = pdd_pkg::DIST_BITS_DEF,
  parameter int PCT_FRAC_BITS = pdd_pkg::PCT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [1:0]                        in_tuser,  // kind
  input  logic [31:0]                       in_tdata,  // left_mm, right_mm
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status_led, bar_mask, left_percent, right_percent, zone, seg_left_hundreds,
  // seg_left_tens, seg_left_ones, seg_separator, seg_right_hundreds,
  // seg_right_tens, seg_right_ones
  output logic [79:0]                       out_tdata,
  input  logic                              cfg_we,
  input  logic [pdd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdd_pkg::MM_W-1:0]          cfg_wdata
);

  localparam int MW  = pdd_pkg::MM_W;
  localparam int DW  = (DIST_BITS < MW) ? DIST_BITS : MW;
  localparam int PW  = pdd_pkg::PCT_INT_W + PCT_FRAC_BITS;
  localparam int NW  = MW + 7 + PCT_FRAC_BITS;
  localparam logic [PW-1:0] PCT_SAT = PW'(999) << PCT_FRAC_BITS;
  localparam logic [PW-1:0] PCT_20  = PW'(20) << PCT_FRAC_BITS;
  localparam logic [PW-1:0] PCT_100 = PW'(100) << PCT_FRAC_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_DIGIT  = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic          side_r, side_nxt;
  logic [pdd_pkg::KIND_W-1:0] kind_r;
  logic [MW-1:0] lmm_r, rmm_r;
  logic [MW-1:0] lmin_r, lmax_r, rmin_r, rmax_r;

  logic          active_r, bvalid_r;
  logic [PW-1:0] lq_r, rq_r, bq_r;
  logic [pdd_pkg::ZONE_W-1:0] zone_r;
  logic [pdd_pkg::SEG_W-1:0]  seg_r [7];

  logic          out_valid_r;
  logic [79:0]   out_data_r;

  // Per-side operands.
  logic [MW-1:0] d_c, lo_c, hi_c, x_c, span_c;
  logic          zero_c;
  logic [NW-1:0] num_c;

  logic              div_start;
  pdd_pkg::div_stat_t div_stat;
  logic [PW-1:0]     div_quo;
  logic [PW-1:0]     q_div;

  logic              dig_start;
  logic [PW-1:0]     dig_q;
  pdd_pkg::dig_res_t dig_res;

  logic [PW-1:0]     bq_c;
  logic [PW:0]       bar_diff;
  logic [pdd_pkg::BAR_LEDS-1:0] bar_c;
  logic              out_load;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    if (side_r) begin
      d_c  = MW'(rmm_r[DW-1:0]);
      lo_c = rmin_r;
      hi_c = rmax_r;
    end else begin
      d_c  = MW'(lmm_r[DW-1:0]);
      lo_c = lmin_r;
      hi_c = lmax_r;
    end
  end

  assign zero_c = (hi_c <= lo_c) || (d_c <= lo_c);
  assign x_c    = d_c - lo_c;
  assign span_c = hi_c - lo_c;
  assign num_c  = (NW'(x_c) * NW'(100)) << PCT_FRAC_BITS;

  assign q_div = (div_stat.ovf || div_quo > PCT_SAT) ? PCT_SAT : div_quo;

  pdd_div #(.NW(NW), .PW(PW), .SW(MW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_c),
    .den   (span_c),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  pdd_digits #(.PCT_FRAC_BITS(PCT_FRAC_BITS)) u_digits (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dig_start),
    .q     (dig_q),
    .res   (dig_res)
  );

  // Bar: LED k is lit when 2*(100 - p) reaches (k+1)*25, for a level inside the span.
  assign bar_diff = {PCT_100 - bq_r, 1'b0};
  always_comb begin
    for (int k = 0; k < pdd_pkg::BAR_LEDS; k++) begin
      bar_c[k] = bar_diff >= ((PW + 1)'((k + 1) * 25) << PCT_FRAC_BITS);
    end
    if (!active_r || !bvalid_r || bq_r >= PCT_100) begin
      bar_c = '0;
    end else if (bq_r <= PCT_20) begin
      bar_c = '1;
    end
  end

  assign bq_c     = (lq_r < rq_r) ? lq_r : rq_r;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    div_start = 1'b0;
    dig_start = 1'b0;
    dig_q     = q_div;
    case (state_r)
      S_IDLE: begin
        side_nxt = 1'b0;
        if (in_tvalid) begin
          state_nxt = (in_tuser == pdd_pkg::KIND_MEAS) ? S_PREP : S_UPDATE;
        end
      end
      S_PREP: begin
        if (zero_c) begin
          dig_start = 1'b1;
          dig_q     = '0;
          state_nxt = S_DIGIT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          dig_start = 1'b1;
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (dig_res.done) begin
          if (side_r) begin
            state_nxt = S_UPDATE;
          end else begin
            side_nxt  = 1'b1;
            state_nxt = S_PREP;
          end
        end
      end
      S_UPDATE: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
      lmin_r      <= pdd_pkg::MIN_MM_RST;
      lmax_r      <= pdd_pkg::MAX_MM_RST;
      rmin_r      <= pdd_pkg::MIN_MM_RST;
      rmax_r      <= pdd_pkg::MAX_MM_RST;
      active_r    <= 1'b0;
      bvalid_r    <= 1'b0;
      lq_r        <= '0;
      rq_r        <= '0;
      bq_r        <= '0;
      zone_r      <= pdd_pkg::ZONE_OK;
      for (int i = 0; i < 7; i++) begin
        seg_r[i] <= pdd_pkg::SEG_BLANK;
      end
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;

      if (cfg_we) begin
        case (cfg_index)
          pdd_pkg::CFG_LEFT_MIN:  lmin_r <= cfg_wdata;
          pdd_pkg::CFG_LEFT_MAX:  lmax_r <= cfg_wdata;
          pdd_pkg::CFG_RIGHT_MIN: rmin_r <= cfg_wdata;
          pdd_pkg::CFG_RIGHT_MAX: rmax_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (dig_start) begin
        if (side_r) begin
          rq_r <= dig_q;
        end else begin
          lq_r <= dig_q;
        end
      end

      if (dig_res.done && state_r == S_DIGIT) begin
        if (side_r) begin
          seg_r[4] <= dig_res.hund;
          seg_r[5] <= dig_res.tens;
          seg_r[6] <= dig_res.ones;
          seg_r[3] <= pdd_pkg::SEG_DASH;
        end else begin
          seg_r[0] <= dig_res.hund;
          seg_r[1] <= dig_res.tens;
          seg_r[2] <= dig_res.ones;
        end
      end

      if (state_r == S_UPDATE) begin
        case (kind_r)
          pdd_pkg::KIND_MEAS: begin
            if (lq_r < PCT_20 || rq_r < PCT_20) begin
              zone_r <= pdd_pkg::ZONE_CONTACT;
            end else if (lq_r > PCT_100 && rq_r > PCT_100) begin
              zone_r <= pdd_pkg::ZONE_NONE;
            end else begin
              zone_r <= pdd_pkg::ZONE_OK;
            end
            bq_r     <= bq_c;
            bvalid_r <= 1'b1;
          end
          pdd_pkg::KIND_ACT: begin
            if (!active_r) begin
              bvalid_r <= 1'b0;
            end
            active_r <= 1'b1;
          end
          pdd_pkg::KIND_DEACT: begin
            active_r <= 1'b0;
            for (int i = 0; i < 7; i++) begin
              seg_r[i] <= pdd_pkg::SEG_BLANK;
            end
          end
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      lmm_r  <= in_tdata[15:0];
      rmm_r  <= in_tdata[31:16];
    end

    if (out_load) begin
      out_data_r <= {seg_r[6], seg_r[5], seg_r[4], seg_r[3], seg_r[2], seg_r[1],
                     seg_r[0], zone_r, rq_r[PW-1:PCT_FRAC_BITS],
                     lq_r[PW-1:PCT_FRAC_BITS], bar_c, active_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An accepted item blocks the input until its work is done.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after an item was accepted");

  // The divider reports only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide step");

  // A lit bar only ever goes out while the system is active.
  a_bar_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8:1] == 8'd0 || out_tdata[0]))
    else $error("bar lit while the system is inactive");

  // The zone code of a result is always a defined zone.
  a_zone_defined: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[30:29] != 2'd3)
    else $error("undefined zone in result");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the parking distance display core with its own display predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC  = pdd_pkg::PCT_FRAC_BITS_DEF;
  localparam int LVL_W = pdd_pkg::PCT_INT_W + FRAC;
  localparam logic [LVL_W-1:0] PCT_20  = LVL_W'(20 << FRAC);
  localparam logic [LVL_W-1:0] PCT_100 = LVL_W'(100 << FRAC);
  localparam logic [LVL_W-1:0] PCT_SAT = LVL_W'(999 << FRAC);
  localparam logic [pdd_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AT     = 1200;
  localparam int RUN_ITEMS   = 220;

  typedef struct {
    logic [pdd_pkg::KIND_W-1:0] kind;
    logic [pdd_pkg::MM_W-1:0]   left_mm;
    logic [pdd_pkg::MM_W-1:0]   right_mm;
  } reading_t;

  // Packed from the top bit down, so a cast of out_tdata lines up.
  typedef struct packed {
    logic [pdd_pkg::SEG_W-1:0]     seg_r_ones;
    logic [pdd_pkg::SEG_W-1:0]     seg_r_tens;
    logic [pdd_pkg::SEG_W-1:0]     seg_r_hund;
    logic [pdd_pkg::SEG_W-1:0]     seg_sep;
    logic [pdd_pkg::SEG_W-1:0]     seg_l_ones;
    logic [pdd_pkg::SEG_W-1:0]     seg_l_tens;
    logic [pdd_pkg::SEG_W-1:0]     seg_l_hund;
    logic [pdd_pkg::ZONE_W-1:0]    zone;
    logic [pdd_pkg::PCT_INT_W-1:0] right_pct;
    logic [pdd_pkg::PCT_INT_W-1:0] left_pct;
    logic [pdd_pkg::BAR_LEDS-1:0]  bar;
    logic                          status;
  } display_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = '0;      // kind
  logic [31:0] in_tdata = '0;     // left_mm, right_mm
  logic out_tvalid;
  logic out_tready = 1'b0;
  // status_led, bar_mask, left_percent, right_percent, zone, seg_left_hundreds,
  // seg_left_tens, seg_left_ones, seg_separator, seg_right_hundreds,
  // seg_right_tens, seg_right_ones
  logic [79:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [pdd_pkg::CFG_IDX_W-1:0] cfg_index = pdd_pkg::CFG_LEFT_MIN;
  logic [pdd_pkg::MM_W-1:0] cfg_wdata = '0;

  parking_distance_display_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Calibration and display state as the block should hold it.
  logic [pdd_pkg::MM_W-1:0]  lmin = pdd_pkg::MIN_MM_RST, lmax = pdd_pkg::MAX_MM_RST;
  logic [pdd_pkg::MM_W-1:0]  rmin = pdd_pkg::MIN_MM_RST, rmax = pdd_pkg::MAX_MM_RST;
  logic             sys_on = 1'b0, bar_ok = 1'b0;
  logic [LVL_W-1:0] bar_lvl = '0, lvl_l = '0, lvl_r = '0;
  logic [pdd_pkg::ZONE_W-1:0] zone_q = pdd_pkg::ZONE_OK;
  logic [pdd_pkg::SEG_W-1:0] seg_q [7] = '{default: pdd_pkg::SEG_BLANK};

  reading_t readings_q[$];
  display_t disp_due_q[$];
  reading_t cur_reading;
  logic in_took = 1'b0;
  int in_count = 0, res_count = 0, err_cnt = 0, quiet_cycles = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int settings_done = 0;

  initial forever #2 clk = ~clk;

  function automatic logic [pdd_pkg::SEG_W-1:0] digit_pattern(input int digit);
    case (digit)
      0: return 7'h3F;
      1: return 7'h06;
      2: return 7'h5B;
      3: return 7'h4F;
      4: return 7'h66;
      5: return 7'h6D;
      6: return 7'h7D;
      7: return 7'h07;
      8: return 7'h7F;
      default: return 7'h6F;
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] span_percent(input logic [pdd_pkg::MM_W-1:0] d, lo, hi);
    logic [63:0] q;
    if (hi <= lo || d <= lo) return '0;
    q = (64'(d - lo) * (64'd100 << FRAC)) / 64'(hi - lo);
    if (q > 64'(PCT_SAT)) q = 64'(PCT_SAT);
    return q[LVL_W-1:0];
  endfunction

  // Hundreds, tens and ones patterns of one side, dashes near contact.
  function automatic logic [3*pdd_pkg::SEG_W-1:0] side_digits(input logic [LVL_W-1:0] q);
    int p;
    logic [pdd_pkg::SEG_W-1:0] hund;
    if (q <= PCT_20) return {3{pdd_pkg::SEG_DASH}};
    p = int'(q >> FRAC);
    if (p > 999) p = 999;
    hund = (p >= 100) ? digit_pattern(p / 100) : pdd_pkg::SEG_BLANK;
    return {hund, digit_pattern((p / 10) % 10), digit_pattern(p % 10)};
  endfunction

  function automatic logic [pdd_pkg::BAR_LEDS-1:0] bar_leds();
    int n;
    logic [pdd_pkg::BAR_LEDS:0] m;
    if (!sys_on || !bar_ok) return '0;
    if (bar_lvl <= PCT_20) return 8'hFF;
    if (bar_lvl >= PCT_100) return '0;
    n = int'(((PCT_100 - bar_lvl) * 2) / (25 << FRAC));
    if (n > pdd_pkg::BAR_LEDS) n = pdd_pkg::BAR_LEDS;
    m = (9'd1 << n) - 9'd1;
    return m[pdd_pkg::BAR_LEDS-1:0];
  endfunction

  task automatic advance_display(input logic [pdd_pkg::KIND_W-1:0] kind,
                                 input logic [pdd_pkg::MM_W-1:0] l_mm, r_mm);
    display_t e;
    logic [3*pdd_pkg::SEG_W-1:0] side;
    int i;
    case (kind)
      pdd_pkg::KIND_MEAS: begin
        lvl_l = span_percent(l_mm, lmin, lmax);
        lvl_r = span_percent(r_mm, rmin, rmax);
        if (lvl_l < PCT_20 || lvl_r < PCT_20) zone_q = pdd_pkg::ZONE_CONTACT;
        else if (lvl_l > PCT_100 && lvl_r > PCT_100) zone_q = pdd_pkg::ZONE_NONE;
        else zone_q = pdd_pkg::ZONE_OK;
        bar_lvl = (lvl_l < lvl_r) ? lvl_l : lvl_r;
        bar_ok = 1'b1;
        side = side_digits(lvl_l);
        {seg_q[0], seg_q[1], seg_q[2]} = side;
        seg_q[3] = pdd_pkg::SEG_DASH;
        side = side_digits(lvl_r);
        {seg_q[4], seg_q[5], seg_q[6]} = side;
      end
      pdd_pkg::KIND_ACT: begin
        if (!sys_on) bar_ok = 1'b0;
        sys_on = 1'b1;
      end
      pdd_pkg::KIND_DEACT: begin
        sys_on = 1'b0;
        for (i = 0; i < 7; i++) seg_q[i] = pdd_pkg::SEG_BLANK;
      end
      default: ;
    endcase
    e.status     = sys_on;
    e.bar        = bar_leds();
    e.left_pct   = lvl_l[LVL_W-1:FRAC];
    e.right_pct  = lvl_r[LVL_W-1:FRAC];
    e.zone       = zone_q;
    e.seg_l_hund = seg_q[0];
    e.seg_l_tens = seg_q[1];
    e.seg_l_ones = seg_q[2];
    e.seg_sep    = seg_q[3];
    e.seg_r_hund = seg_q[4];
    e.seg_r_tens = seg_q[5];
    e.seg_r_ones = seg_q[6];
    disp_due_q.push_back(e);
  endtask

  task automatic check_field(input string name, input logic [pdd_pkg::PCT_INT_W-1:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  task automatic compare_display(input display_t want, input display_t got);
    check_field("status_led", 10'(want.status), 10'(got.status));
    check_field("bar_mask", 10'(want.bar), 10'(got.bar));
    check_field("left_percent", want.left_pct, got.left_pct);
    check_field("right_percent", want.right_pct, got.right_pct);
    check_field("zone", 10'(want.zone), 10'(got.zone));
    check_field("seg_left_hundreds", 10'(want.seg_l_hund), 10'(got.seg_l_hund));
    check_field("seg_left_tens", 10'(want.seg_l_tens), 10'(got.seg_l_tens));
    check_field("seg_left_ones", 10'(want.seg_l_ones), 10'(got.seg_l_ones));
    check_field("seg_separator", 10'(want.seg_sep), 10'(got.seg_sep));
    check_field("seg_right_hundreds", 10'(want.seg_r_hund), 10'(got.seg_r_hund));
    check_field("seg_right_tens", 10'(want.seg_r_tens), 10'(got.seg_r_tens));
    check_field("seg_right_ones", 10'(want.seg_r_ones), 10'(got.seg_r_ones));
  endtask

  // The idle mix moves on with the number of items taken in so far.
  function automatic int sender_idle_pct();
    if (in_count < 520) return 12;
    if (in_count < 1040) return 86;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (in_count < 520) return 86;
    if (in_count < 1040) return 12;
    return 0;
  endfunction

  always @(posedge clk) begin
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      advance_display(in_tuser, in_tdata[15:0], in_tdata[31:16]);
      in_count++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (disp_due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
        err_cnt++;
      end else begin
        compare_display(disp_due_q.pop_front(), display_t'(out_tdata));
      end
      res_count++;
    end
    if ((rst_n && in_tvalid && in_tready) || (rst_n && out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  // Sender: a new item goes up only once the previous one was taken.
  always @(negedge clk) begin
    if (!in_tvalid || in_took) begin
      if (readings_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
        cur_reading = readings_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= cur_reading.kind;
        in_tdata  <= {cur_reading.right_mm, cur_reading.left_mm};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off that lets the block back up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && res_count >= HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("parking_distance_display_core test failed");
    $finish;
  end

  task automatic push_item(input logic [pdd_pkg::KIND_W-1:0] kind,
                           input logic [pdd_pkg::MM_W-1:0] l, r);
    reading_t it;
    it.kind     = kind;
    it.left_mm  = l;
    it.right_mm = r;
    readings_q.push_back(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (readings_q.size() != 0 || in_tvalid || disp_due_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_limits(input logic [pdd_pkg::MM_W-1:0] l0, l1, r0, r1);
    lmin = l0;
    lmax = l1;
    rmin = r0;
    rmax = r1;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= pdd_pkg::CFG_LEFT_MIN;
    cfg_wdata <= l0;
    @(negedge clk);
    cfg_index <= pdd_pkg::CFG_LEFT_MAX;
    cfg_wdata <= l1;
    @(negedge clk);
    cfg_index <= pdd_pkg::CFG_RIGHT_MIN;
    cfg_wdata <= r0;
    @(negedge clk);
    cfg_index <= pdd_pkg::CFG_RIGHT_MAX;
    cfg_wdata <= r1;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // Distances cluster around the calibrated span and its thresholds.
  function automatic logic [pdd_pkg::MM_W-1:0] pick_mm(input logic [pdd_pkg::MM_W-1:0] lo, hi);
    int a, b, span, v;
    a = (lo < hi) ? int'(lo) : int'(hi);
    b = (lo < hi) ? int'(hi) : int'(lo);
    span = b - a;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 65535);
      1: v = $urandom_range(0, 1) ? 65535 : 0;
      2: v = lo;
      3: v = int'(lo) + 1;
      4: v = hi;
      5: v = int'(hi) + $urandom_range(0, 2) - 1;
      6: v = int'(lo) + span / 5 + $urandom_range(0, 4) - 2;
      default: v = $urandom_range(a, b + span / 8);
    endcase
    return v[pdd_pkg::MM_W-1:0];
  endfunction

  function automatic logic [pdd_pkg::MM_W-1:0] rand_mm();
    return pdd_pkg::MM_W'($urandom);
  endfunction

  task automatic queue_random_run(input int n);
    int i, r;
    push_item(pdd_pkg::KIND_ACT, rand_mm(), rand_mm());
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) push_item(pdd_pkg::KIND_MEAS, pick_mm(lmin, lmax), pick_mm(rmin, rmax));
      else if (r < 88) push_item(pdd_pkg::KIND_ACT, rand_mm(), rand_mm());
      else if (r < 95) push_item(pdd_pkg::KIND_DEACT, rand_mm(), rand_mm());
      else push_item(KIND_UNUSED, rand_mm(), rand_mm());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset calibration: 200 to 1000 mm, so 360 mm is exactly 20 percent.
    push_item(pdd_pkg::KIND_MEAS, 16'd0, 16'd0);
    push_item(pdd_pkg::KIND_ACT, 16'hFFFF, 16'hFFFF);
    push_item(pdd_pkg::KIND_ACT, 16'd0, 16'd0);
    push_item(pdd_pkg::KIND_MEAS, 16'd360, 16'd360);
    push_item(pdd_pkg::KIND_MEAS, 16'd359, 16'd1000);
    push_item(pdd_pkg::KIND_MEAS, 16'd1000, 16'd1000);
    push_item(pdd_pkg::KIND_MEAS, 16'd1001, 16'd1200);
    push_item(pdd_pkg::KIND_MEAS, 16'hFFFF, 16'hFFFF);
    push_item(pdd_pkg::KIND_MEAS, 16'd600, 16'd700);
    push_item(pdd_pkg::KIND_MEAS, 16'd361, 16'd361);
    push_item(pdd_pkg::KIND_MEAS, 16'd950, 16'd990);
    push_item(KIND_UNUSED, 16'h5A5A, 16'hA5A5);
    push_item(pdd_pkg::KIND_MEAS, 16'd200, 16'd201);
    push_item(pdd_pkg::KIND_DEACT, 16'd0, 16'd0);
    push_item(pdd_pkg::KIND_MEAS, 16'd700, 16'd800);
    push_item(pdd_pkg::KIND_DEACT, 16'd0, 16'd0);
    push_item(KIND_UNUSED, 16'd0, 16'd0);
    push_item(pdd_pkg::KIND_ACT, 16'd0, 16'd0);
    push_item(pdd_pkg::KIND_MEAS, 16'hFFFF, 16'd0);
    push_item(pdd_pkg::KIND_MEAS, 16'd520, 16'd840);
    push_item(pdd_pkg::KIND_ACT, 16'd0, 16'd0);
    push_item(pdd_pkg::KIND_MEAS, 16'd999, 16'd400);
    wait_idle();

    set_limits(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    queue_random_run(RUN_ITEMS);
    wait_idle();
    set_limits(16'd500, 16'd500, 16'd0, 16'd1);
    queue_random_run(RUN_ITEMS);
    wait_idle();
    set_limits(16'd100, 16'd400, 16'd300, 16'd2000);
    queue_random_run(RUN_ITEMS);
    wait_idle();
    set_limits(16'd0, 16'd100, 16'd65000, 16'hFFFF);
    queue_random_run(RUN_ITEMS);
    wait_idle();
    set_limits(rand_mm(), rand_mm(), rand_mm(), rand_mm());
    queue_random_run(RUN_ITEMS);
    wait_idle();
    set_limits(pdd_pkg::MM_W'($urandom_range(0, 2000)), pdd_pkg::MM_W'($urandom_range(500, 5000)),
               pdd_pkg::MM_W'($urandom_range(0, 2000)), pdd_pkg::MM_W'($urandom_range(500, 5000)));
    queue_random_run(RUN_ITEMS);
    wait_idle();
    set_limits(pdd_pkg::MIN_MM_RST, pdd_pkg::MAX_MM_RST, pdd_pkg::MIN_MM_RST, pdd_pkg::MAX_MM_RST);
    queue_random_run(RUN_ITEMS);
    wait_idle();

    if (disp_due_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, disp_due_q.size());
      err_cnt++;
    end
    $display("Ran %0d items and checked %0d results under %0d calibration settings,",
             in_count, res_count, settings_done + 1);
    $display("including zero, negative and full-scale spans and a long output hold-off.");
    if (err_cnt == 0) begin
      $display("parking_distance_display_core test passed");
    end else begin
      $display("parking_distance_display_core test failed");
    end
    $finish;
  end

endmodule
